// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the console RTL.
// Every macro expects clock aclk and active-low reset aresetn in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset.
`define TCW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Geometry, character codes, beat structs and internal control structs of
// the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int ROWS          = 25;
    localparam int COLUMNS       = 80;
    localparam int TAB_STEP      = 4;
    localparam int CELL_COUNT    = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = CELL_COUNT - COLUMNS;
    localparam int ADDR_W        = $clog2(CELL_COUNT);
    localparam int ROW_W         = $clog2(ROWS + 1);
    localparam int COL_W         = $clog2(COLUMNS);
    localparam int SUM_W         = COL_W + 1;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0]  RESET_COLOR = 8'd2;
    localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};

    // Opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [10:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } out_item_t;

    // Screen memory port request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef enum logic {
        SWK_FILL   = 1'b0,
        SWK_SCROLL = 1'b1
    } sw_kind_t;

    typedef struct packed {
        logic        start;
        sw_kind_t    kind;
        logic [15:0] value;
    } sw_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sw_stat_t;

endpackage

// ===== src/tcw_ram.sv =====
// ---------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tcw_sweep.sv =====
// ---------------------------------------------------------------------------
// tcw_sweep
// Walks the screen memory: fills every cell with one value, or scrolls the
// screen up by one row and blanks the last row. One cell per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_sweep (
    input  logic               aclk,
    input  logic               aresetn,
    input  tcw_pkg::sw_cmd_t   cmd,
    input  logic [15:0]        rdata,
    output tcw_pkg::sw_stat_t  stat,
    output tcw_pkg::mem_req_t  req
);

    localparam int AW = tcw_pkg::ADDR_W;

    typedef enum logic [2:0] {
        SW_IDLE = 3'b001,
        SW_COPY = 3'b010,
        SW_FILL = 3'b100
    } sw_state_t;

    sw_state_t       state_reg, state_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [15:0]     value_reg, value_next;
    logic            pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]   pipe_addr_reg, pipe_addr_next;
    logic            done_reg, done_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SW_IDLE;
            pipe_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pipe_valid_reg <= pipe_valid_next;
            done_reg       <= done_next;
        end
        ptr_reg       <= ptr_next;
        value_reg     <= value_next;
        pipe_addr_reg <= pipe_addr_next;
    end

    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        value_next      = value_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        done_next       = 1'b0;
        req             = '0;

        unique case (state_reg)
            SW_IDLE: begin
                if (cmd.start) begin
                    value_next = cmd.value;
                    ptr_next   = '0;
                    state_next = (cmd.kind == tcw_pkg::SWK_SCROLL) ? SW_COPY : SW_FILL;
                end
            end
            SW_COPY: begin
                // read one row below, write it back in the next cycle
                if (ptr_reg < AW'(tcw_pkg::LAST_ROW_BASE)) begin
                    req.raddr       = ptr_reg + AW'(tcw_pkg::COLUMNS);
                    pipe_valid_next = 1'b1;
                    pipe_addr_next  = ptr_reg;
                    ptr_next        = ptr_reg + AW'(1);
                end else begin
                    state_next = SW_FILL;
                end
            end
            SW_FILL: begin
                req.we    = 1'b1;
                req.waddr = ptr_reg;
                req.wdata = value_reg;
                if (ptr_reg == AW'(tcw_pkg::CELL_COUNT - 1)) begin
                    state_next = SW_IDLE;
                    done_next  = 1'b1;
                end else begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            default: begin
                state_next = SW_IDLE;
            end
        endcase

        if (pipe_valid_reg) begin
            req.we    = 1'b1;
            req.waddr = pipe_addr_reg;
            req.wdata = rdata;
        end
    end

    assign stat.busy = (state_reg != SW_IDLE);
    assign stat.done = done_reg;

    `TCW_ASSERT_IMPL(a_sw_done_idle, done_reg, state_reg == SW_IDLE, "sweep done while busy")
    `TCW_ASSERT_IMPL(a_sw_wr_range, req.we, 32'(req.waddr) < tcw_pkg::CELL_COUNT,
                     "sweep write out of range")
    `TCW_ASSERT_IMPL(a_sw_copy_dst, pipe_valid_reg,
                     32'(pipe_addr_reg) < tcw_pkg::LAST_ROW_BASE, "copy wrote into last row")

endmodule

// ===== src/text_console_writer.sv =====
// ---------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen of 16-bit cells in one RAM, cursor in registers.
// Puts characters, reads cells, clears the screen.
//
//   channel  | ports                       | beat
//   ---------+-----------------------------+-----------------------------
//   input    | s_valid s_ready s_data      | opcode, char_code, address
//   result   | m_valid m_ready m_data      | cell, cursor row and column
//   config   | cfg_valid cfg_ready cfg_data| text_color (always ready)
//
// Put, read of a missing cell and unused opcode finish from ST_EXEC; a read
// of a real cell goes on through ST_READ. Clear, a wrap scroll and a pending
// scroll each run a sweep of the screen memory before the result.
// After reset a clearing pass holds s_ready low.
// A result waiting on m_ready parks the next beat in place; s_ready is high
// only when no beat is executing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcw_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tcw_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int RW = tcw_pkg::ROW_W;
    localparam int CW = tcw_pkg::COL_W;
    localparam int SW = tcw_pkg::SUM_W;

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_SWEEP = 6'b010000,
        ST_HOLD  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        AFT_IDLE = 2'd0,
        AFT_PUT  = 2'd1,
        AFT_DONE = 2'd2
    } after_t;

    state_t              state_reg, state_next;
    after_t              after_reg, after_next;
    tcw_pkg::in_item_t   item_reg, item_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [15:0]         res_value_reg, res_value_next;
    tcw_pkg::out_item_t  out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          text_color_reg;

    tcw_pkg::sw_cmd_t    sw_cmd;
    tcw_pkg::sw_stat_t   sw_stat;
    tcw_pkg::mem_req_t   sw_req, top_req, mem_req;
    logic [15:0]         rdata;

    logic                fin;
    logic [15:0]         fin_value;
    logic                out_free;
    logic [15:0]         blank;
    logic [RW-1:0]       row_inc;
    logic [CW-1:0]       bs_col;
    logic [CW-1:0]       put_col;
    logic [AW-1:0]       wr_addr;
    logic [SW-1:0]       adv_col;
    logic                is_tab;

    // ---------------- screen memory and sweep engine ----------------
    tcw_sweep u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sw_cmd),
        .rdata   (rdata),
        .stat    (sw_stat),
        .req     (sw_req)
    );

    assign mem_req = sw_stat.busy ? sw_req : top_req;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (tcw_pkg::CELL_COUNT)
    ) u_screen (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            after_reg      <= AFT_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            out_valid_reg  <= 1'b0;
            text_color_reg <= tcw_pkg::RESET_COLOR;
        end else begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                text_color_reg <= cfg_data;
            end
        end
        item_reg      <= item_next;
        res_value_reg <= res_value_next;
        out_reg       <= out_next;
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign out_free  = !out_valid_reg || m_ready;

    // ---------------- put datapath ----------------
    assign blank   = {text_color_reg, tcw_pkg::CH_SPACE};
    assign row_inc = row_reg + RW'(1);
    assign bs_col  = (col_reg == '0) ? '0 : col_reg - CW'(1);
    assign put_col = (item_reg.char_code == tcw_pkg::CH_BACKSPACE) ? bs_col : col_reg;
    assign wr_addr = AW'(32'(row_reg) * tcw_pkg::COLUMNS + 32'(put_col));
    assign is_tab  = (item_reg.char_code == tcw_pkg::CH_TAB);
    assign adv_col = is_tab ? SW'(col_reg) + SW'(tcw_pkg::TAB_STEP) : SW'(col_reg) + SW'(1);

    // ---------------- control ----------------
    always_comb begin
        state_next     = state_reg;
        after_next     = after_reg;
        item_next      = item_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        res_value_next = res_value_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        sw_cmd         = '0;
        top_req        = '0;
        fin            = 1'b0;
        fin_value      = '0;

        if (m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT: begin
                sw_cmd.start = 1'b1;
                sw_cmd.kind  = tcw_pkg::SWK_FILL;
                sw_cmd.value = tcw_pkg::RESET_BLANK;
                after_next   = AFT_IDLE;
                state_next   = ST_SWEEP;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (item_reg.opcode)
                    tcw_pkg::OP_PUT: begin
                        if (row_reg == RW'(tcw_pkg::ROWS)) begin
                            // pending scroll first, then come back for the byte
                            row_next     = RW'(tcw_pkg::ROWS - 1);
                            sw_cmd.start = 1'b1;
                            sw_cmd.kind  = tcw_pkg::SWK_SCROLL;
                            sw_cmd.value = blank;
                            after_next   = AFT_PUT;
                            state_next   = ST_SWEEP;
                        end else if (item_reg.char_code == tcw_pkg::CH_NEWLINE) begin
                            col_next = '0;
                            row_next = row_inc;
                            fin      = 1'b1;
                        end else if (item_reg.char_code == tcw_pkg::CH_BACKSPACE) begin
                            col_next      = bs_col;
                            top_req.we    = 1'b1;
                            top_req.waddr = wr_addr;
                            top_req.wdata = blank;
                            fin           = 1'b1;
                        end else begin
                            if (!is_tab) begin
                                top_req.we    = 1'b1;
                                top_req.waddr = wr_addr;
                                top_req.wdata = {text_color_reg, item_reg.char_code};
                            end
                            if (32'(adv_col) >= tcw_pkg::COLUMNS) begin
                                col_next = '0;
                                if (row_inc == RW'(tcw_pkg::ROWS)) begin
                                    // wrap off the bottom: scroll now
                                    row_next     = RW'(tcw_pkg::ROWS - 1);
                                    sw_cmd.start = 1'b1;
                                    sw_cmd.kind  = tcw_pkg::SWK_SCROLL;
                                    sw_cmd.value = blank;
                                    after_next   = AFT_DONE;
                                    state_next   = ST_SWEEP;
                                end else begin
                                    row_next = row_inc;
                                    fin      = 1'b1;
                                end
                            end else begin
                                col_next = CW'(adv_col);
                                fin      = 1'b1;
                            end
                        end
                    end
                    tcw_pkg::OP_READ: begin
                        if (32'(item_reg.cell_address) < tcw_pkg::CELL_COUNT) begin
                            top_req.raddr = AW'(item_reg.cell_address);
                            state_next    = ST_READ;
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        row_next     = '0;
                        col_next     = '0;
                        sw_cmd.start = 1'b1;
                        sw_cmd.kind  = tcw_pkg::SWK_FILL;
                        sw_cmd.value = blank;
                        after_next   = AFT_DONE;
                        state_next   = ST_SWEEP;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_READ: begin
                fin       = 1'b1;
                fin_value = rdata;
            end
            ST_SWEEP: begin
                if (sw_stat.done) begin
                    unique case (after_reg)
                        AFT_IDLE: state_next = ST_IDLE;
                        AFT_PUT:  state_next = ST_EXEC;
                        AFT_DONE: fin        = 1'b1;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_next.cell_value    = res_value_reg;
                    out_next.cursor_row    = 5'(row_reg);
                    out_next.cursor_column = 7'(col_reg);
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // deliver the result now, or park it until the output frees up
        if (fin) begin
            res_value_next = fin_value;
            if (out_free) begin
                out_next.cell_value    = fin_value;
                out_next.cursor_row    = 5'(row_next);
                out_next.cursor_column = 7'(col_next);
                out_valid_next         = 1'b1;
                state_next             = ST_IDLE;
            end else begin
                state_next = ST_HOLD;
            end
        end
    end

    `TCW_ASSERT_NEXT(a_accept_exec, s_valid && s_ready, state_reg == ST_EXEC,
                     "accepted beat not executed")
    `TCW_ASSERT_IMPL(a_ready_quiet, s_ready, !sw_stat.busy, "ready while memory sweep runs")
    `TCW_ASSERT(a_row_bound, 32'(row_reg) <= tcw_pkg::ROWS, "cursor row past pending scroll")
    `TCW_ASSERT(a_col_bound, 32'(col_reg) < tcw_pkg::COLUMNS, "cursor column past width")

endmodule

// ===== verif/text_console_writer_checker.sv =====
// ----------------------------------------------------------------------------
// Text console writer result checker
// Watches the input, result and color channels of the console. Keeps its own
// copy of the screen, cursor and text color, works out the report that every
// accepted beat should produce, and compares each result beat with the oldest
// report still owed.
// ----------------------------------------------------------------------------
module text_console_writer_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tcw_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tcw_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [7:0]          cfg_data,
    output int                  errors,
    output int                  reports_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    logic [15:0]        glyphs [CELL_COUNT];
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    logic [7:0]         ink;
    out_item_t          console_reports [$];
    out_item_t          fresh_report;
    out_item_t          owed_report;
    int                 mismatches = 0;
    int                 owed_count = 0;

    assign errors       = mismatches;
    assign reports_owed = owed_count;

    function automatic logic [15:0] blank_glyph();
        return {ink, CH_SPACE};
    endfunction

    task automatic wipe_screen();
        for (int i = 0; i < CELL_COUNT; i++) begin
            glyphs[i] = blank_glyph();
        end
        cur_row = '0;
        cur_col = '0;
    endtask

    task automatic scroll_screen();
        for (int i = 0; i < LAST_ROW_BASE; i++) begin
            glyphs[i] = glyphs[i + COLUMNS];
        end
        for (int i = LAST_ROW_BASE; i < CELL_COUNT; i++) begin
            glyphs[i] = blank_glyph();
        end
        cur_row = ROW_W'(ROWS - 1);
    endtask

    // Column ran off the right edge: start the next line, scrolling at once
    // when it falls off the bottom.
    task automatic wrap_cursor();
        if (cur_col >= COLUMNS) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
            if (cur_row >= ROWS) begin
                scroll_screen();
            end
        end
    endtask

    task automatic type_char(input logic [7:0] c);
        int slot;
        // A newline on the last row leaves the scroll for the next put.
        if (cur_row >= ROWS) begin
            scroll_screen();
        end
        slot = cur_row * COLUMNS + cur_col;
        if (c == CH_NEWLINE) begin
            cur_col = '0;
            cur_row = cur_row + 1'b1;
        end else if (c == CH_TAB) begin
            cur_col = cur_col + COL_W'(TAB_STEP);
            wrap_cursor();
        end else if (c == CH_BACKSPACE) begin
            if (cur_col > 0) begin
                cur_col = cur_col - 1'b1;
            end
            glyphs[cur_row * COLUMNS + cur_col] = blank_glyph();
        end else begin
            glyphs[slot] = {ink, c};
            cur_col = cur_col + 1'b1;
            wrap_cursor();
        end
    endtask

    task automatic run_console_op(input in_item_t op, output out_item_t rpt);
        logic [15:0] cell_read;
        cell_read = '0;
        case (op.opcode)
            OP_PUT: begin
                type_char(op.char_code);
            end
            OP_READ: begin
                if (op.cell_address < CELL_COUNT) begin
                    cell_read = glyphs[op.cell_address];
                end
            end
            OP_CLEAR: begin
                wipe_screen();
            end
            default: begin
            end
        endcase
        rpt.cell_value    = cell_read;
        rpt.cursor_row    = cur_row;
        rpt.cursor_column = cur_col;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ink = RESET_COLOR;
            wipe_screen();
            console_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                ink = cfg_data;
            end
            // Queue the new report before popping: it always lands behind older ones.
            if (s_valid && s_ready) begin
                run_console_op(s_data, fresh_report);
                console_reports.push_back(fresh_report);
            end
            if (m_valid && m_ready) begin
                if (console_reports.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t ns: result beat with nothing owed,", $time,
                             " actual cell %h row %0d col %0d", m_data.cell_value,
                             m_data.cursor_row, m_data.cursor_column);
                end else begin
                    owed_report = console_reports.pop_front();
                    if (m_data.cell_value !== owed_report.cell_value
                        || m_data.cursor_row !== owed_report.cursor_row
                        || m_data.cursor_column !== owed_report.cursor_column) begin
                        mismatches = mismatches + 1;
                        $display("%0t ns: mismatch, expected cell %h row %0d col %0d,",
                                 $time, owed_report.cell_value, owed_report.cursor_row,
                                 owed_report.cursor_column,
                                 " actual cell %h row %0d col %0d", m_data.cell_value,
                                 m_data.cursor_row, m_data.cursor_column);
                    end
                end
            end
        end
        owed_count <= console_reports.size();
    end

endmodule

// ===== verif/text_console_writer_test.sv =====
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives puts, reads, clears and unused opcodes into the console with random
// gaps on the input side and random stalls on the result side, changes the
// text color between phases while the console is idle, and lets the checker
// beside the block judge every result beat.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         PHASES       = 12;
    localparam int         PHASE_BEATS  = 38;
    localparam int         TAIL_CYCLES  = 20;
    localparam int         ADDR_TOP     = (1 << ADDR_W) - 1;

    typedef enum {MIX_TEXT, MIX_LINES, MIX_TABS, MIX_READS} mix_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    int         errors;
    int         reports_owed;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    text_console_writer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    text_console_writer_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .reports_owed (reports_owed)
    );

    // Hold valid and payload until the beat is taken; end on a falling edge.
    task automatic send_beat(input in_item_t beat, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= beat;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle_console();
        s_valid <= 1'b0;
        while (reports_owed != 0) @(negedge aclk);
    endtask

    task automatic write_color(input logic [7:0] color);
        cfg_data  <= color;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int sender_gap(input bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t random_beat(input mix_t mix);
        in_item_t b;
        int       r;
        int       rd_pct;
        int       nl_pct;
        int       tab_pct;
        int       bs_pct;
        case (mix)
            MIX_LINES: begin rd_pct = 10; nl_pct = 40; tab_pct = 5;  bs_pct = 5; end
            MIX_TABS:  begin rd_pct = 10; nl_pct = 3;  tab_pct = 30; bs_pct = 5; end
            MIX_READS: begin rd_pct = 50; nl_pct = 8;  tab_pct = 6;  bs_pct = 6; end
            default:   begin rd_pct = 12; nl_pct = 8;  tab_pct = 6;  bs_pct = 6; end
        endcase
        b.opcode       = OP_PUT;
        b.char_code    = 8'($urandom_range(0, 255));
        b.cell_address = ADDR_W'($urandom_range(0, ADDR_TOP));
        r = $urandom_range(0, 99);
        if (r < 1) begin
            b.opcode = OP_CLEAR;
        end else if (r < 2) begin
            b.opcode = OP_UNUSED;
        end else if (r < 2 + rd_pct) begin
            b.opcode = OP_READ;
            // Mostly real cells, now and then past the end of the screen.
            if ($urandom_range(0, 9) == 0) begin
                b.cell_address = ADDR_W'($urandom_range(CELL_COUNT, ADDR_TOP));
            end else begin
                b.cell_address = ADDR_W'($urandom_range(0, CELL_COUNT - 1));
            end
        end else begin
            r = $urandom_range(0, 99);
            if (r < nl_pct) begin
                b.char_code = CH_NEWLINE;
            end else if (r < nl_pct + tab_pct) begin
                b.char_code = CH_TAB;
            end else if (r < nl_pct + tab_pct + bs_pct) begin
                b.char_code = CH_BACKSPACE;
            end
        end
        return b;
    endfunction

    // Result side: ready runs broken by stalls, mostly short, a few long.
    initial begin
        int run;
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 12);
            repeat (run) @(negedge aclk);
            m_ready <= 1'b0;
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                : $urandom_range(1, 3);
            repeat (stall) @(negedge aclk);
        end
    end

    initial begin
        mix_t mix;
        bit   eager;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset screen, edges of the address range, cursor control characters.
        send_beat('{OP_READ, 8'h00, 11'd0}, 0);
        send_beat('{OP_READ, 8'hFF, 11'(CELL_COUNT - 1)}, 0);
        send_beat('{OP_READ, 8'h00, 11'(CELL_COUNT)}, 1);
        send_beat('{OP_READ, 8'h00, 11'(ADDR_TOP)}, 0);
        send_beat('{OP_PUT, 8'h41, 11'(ADDR_TOP)}, 0);
        send_beat('{OP_PUT, 8'h00, 11'd0}, 0);
        send_beat('{OP_PUT, 8'hFF, 11'd0}, 2);
        repeat (4) send_beat('{OP_PUT, CH_BACKSPACE, 11'd0}, 0);
        send_beat('{OP_PUT, CH_TAB, 11'd0}, 0);
        send_beat('{OP_PUT, CH_TAB, 11'd0}, 0);
        send_beat('{OP_PUT, CH_NEWLINE, 11'd0}, 0);
        send_beat('{OP_UNUSED, 8'hFF, 11'(ADDR_TOP)}, 0);
        send_beat('{OP_READ, 8'h00, 11'd1}, 0);
        settle_console();
        write_color(8'hFF);
        send_beat('{OP_PUT, 8'h5A, 11'd0}, 0);
        send_beat('{OP_READ, 8'h00, 11'(COLUMNS)}, 0);
        send_beat('{OP_CLEAR, 8'h00, 11'd0}, 0);
        send_beat('{OP_READ, 8'h00, 11'd0}, 0);
        settle_console();
        write_color(8'h00);
        send_beat('{OP_PUT, 8'h78, 11'd0}, 0);
        send_beat('{OP_READ, 8'h00, 11'd0}, 0);

        for (int p = 0; p < PHASES; p++) begin
            settle_console();
            case ($urandom_range(0, 3))
                0:       write_color(8'h00);
                1:       write_color(8'hFF);
                default: write_color(8'($urandom_range(0, 255)));
            endcase
            mix   = mix_t'($urandom_range(0, 3));
            eager = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                send_beat('{OP_CLEAR, 8'($urandom_range(0, 255)),
                            11'($urandom_range(0, ADDR_TOP))}, 0);
            end
            repeat (PHASE_BEATS) send_beat(random_beat(mix), sender_gap(eager));
        end

        settle_console();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("text_console_writer verification clean");
        end else begin
            $display("text_console_writer verification failed");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("text_console_writer verification failed");
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
+incdir+src
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_sweep.sv
src/text_console_writer.sv
verif/text_console_writer_checker.sv
verif/text_console_writer_test.sv
